// ===== sv/gpc_pkg.sv =====
package gpc_pkg;

  localparam int unsigned ROW_PIXELS     = 1024;
  localparam int unsigned OUT_ROW_PIXELS = 1030;
  localparam int unsigned ROW_BITS       = $clog2(ROW_PIXELS);
  localparam int unsigned GAP_BITS       = 8;
  localparam int unsigned LINE_SPLIT     = 256 * ROW_PIXELS;

  localparam int unsigned IDX_W   = 19;
  localparam int unsigned OIDX_W  = 20;
  localparam int unsigned ADC_W   = 14;
  localparam int unsigned Q8_W    = 22;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned DIFF_W  = Q8_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + GAIN_W;
  localparam int unsigned NUM_W   = 29;
  localparam int unsigned RES_W   = 16;

  localparam logic [OIDX_W-1:0] WIDE_GAP = OIDX_W'(2 * OUT_ROW_PIXELS);
  localparam logic [IDX_W-1:0]  LINE_MIN = IDX_W'(LINE_SPLIT);

  // floor(n / 100) == (n * DIV100_MUL) >> DIV100_SHIFT for n < 2**NUM_W
  localparam int unsigned        DIV100_MUL_W = 30;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 30'd687194768;
  localparam int unsigned        DIV100_SHIFT = 36;
  localparam int unsigned        QPROD_W      = NUM_W + DIV100_MUL_W;

  localparam logic [6:0]         TRACK_WEIGHT = 7'd99;
  localparam logic [NUM_W-1:0]   TRACK_ROUND  = 29'd50;

  localparam logic [ADC_W-1:0]   ADC_FULL     = 14'h3fff;
  localparam logic [ADC_W-1:0]   ADC_ZERO     = 14'h0000;
  localparam int unsigned        ROUND_SHIFT  = 24;
  localparam logic [PROD_W:0]    ROUND_HALF   = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);
  localparam int unsigned        MAGR_W       = PROD_W + 1 - ROUND_SHIFT;
  localparam logic [MAGR_W-1:0]  NEG_LIMIT    = MAGR_W'(32768);
  localparam logic [MAGR_W-1:0]  POS_LIMIT    = MAGR_W'(32767);
  localparam logic [RES_W-1:0]   RES_MIN      = 16'h8000;
  localparam logic [RES_W-1:0]   RES_MAX      = 16'h7fff;

  localparam int unsigned        DEPTH        = 6;

  typedef enum logic [1:0] {
    GAIN_STAGE0  = 2'b00,
    GAIN_STAGE1  = 2'b01,
    GAIN_INVALID = 2'b10,
    GAIN_STAGE2  = 2'b11
  } gain_code_e;

  typedef enum logic [1:0] {
    STATUS_NORMAL  = 2'd0,
    STATUS_ZERO    = 2'd1,
    STATUS_SAT     = 2'd2,
    STATUS_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    gain_code_e        code;
    logic [ADC_W-1:0]  adc;
    logic [OIDX_W-1:0] oidx;
    logic [Q8_W-1:0]   p0;
  } side_t;

  typedef struct packed {
    side_t                    side;
    logic signed [GAIN_W-1:0] gain;
    logic signed [DIFF_W-1:0] diff;
  } trk_t;

endpackage

// ===== sv/detector_pixel_gain_pedestal_correct.sv =====
// Pedestal subtraction and gain correction, one pixel per clock. Six register stages:
// tracking window and weighted sum, divide by 100, pedestal subtract, gain multiply,
// magnitude, round and saturate. Throughput is one beat per cycle as long as out_stall_i
// stays low. A stage that holds no beat takes the next one even while the output is
// stalled, so in_stall_o rises only once all six stages are full and the output beat is
// held.
module detector_pixel_gain_pedestal_correct (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [15:0]                        raw_word_i,
  input  logic [gpc_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic signed [gpc_pkg::GAIN_W-1:0]  gain_stage0_i,
  input  logic signed [gpc_pkg::GAIN_W-1:0]  gain_stage1_i,
  input  logic signed [gpc_pkg::GAIN_W-1:0]  gain_stage2_i,
  input  logic [gpc_pkg::Q8_W-1:0]           pedestal_stage0_i,
  input  logic [gpc_pkg::Q8_W-1:0]           pedestal_stage1_i,
  input  logic [gpc_pkg::Q8_W-1:0]           pedestal_stage2_i,
  input  logic [gpc_pkg::Q8_W-1:0]           noise_rms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [gpc_pkg::RES_W-1:0]   corrected_value_o,
  output logic [gpc_pkg::OIDX_W-1:0]         out_index_o,
  output logic [1:0]                         status_o,
  output logic [gpc_pkg::Q8_W-1:0]           new_pedestal_stage0_o
);

  logic [gpc_pkg::DEPTH-1:0] vld_q, vld_d, adv;
  gpc_pkg::trk_t             trk;

  always_comb begin
    adv[gpc_pkg::DEPTH-1] = !vld_q[gpc_pkg::DEPTH-1] || !out_stall_i;
    for (int k = gpc_pkg::DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < gpc_pkg::DEPTH; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  gpc_track u_track (
    .clk_i             (clk_i),
    .en_i              (adv[2:0]),
    .raw_word_i        (raw_word_i),
    .pixel_index_i     (pixel_index_i),
    .gain_stage0_i     (gain_stage0_i),
    .gain_stage1_i     (gain_stage1_i),
    .gain_stage2_i     (gain_stage2_i),
    .pedestal_stage0_i (pedestal_stage0_i),
    .pedestal_stage1_i (pedestal_stage1_i),
    .pedestal_stage2_i (pedestal_stage2_i),
    .noise_rms_i       (noise_rms_i),
    .trk_o             (trk)
  );

  gpc_scale u_scale (
    .clk_i                 (clk_i),
    .en_i                  (adv[5:3]),
    .trk_i                 (trk),
    .corrected_value_o     (corrected_value_o),
    .out_index_o           (out_index_o),
    .status_o              (status_o),
    .new_pedestal_stage0_o (new_pedestal_stage0_o)
  );

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[gpc_pkg::DEPTH-1];

endmodule

// ===== sv/gpc_track.sv =====
module gpc_track (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  logic [15:0]                        raw_word_i,
  input  logic [gpc_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic signed [gpc_pkg::GAIN_W-1:0]  gain_stage0_i,
  input  logic signed [gpc_pkg::GAIN_W-1:0]  gain_stage1_i,
  input  logic signed [gpc_pkg::GAIN_W-1:0]  gain_stage2_i,
  input  logic [gpc_pkg::Q8_W-1:0]           pedestal_stage0_i,
  input  logic [gpc_pkg::Q8_W-1:0]           pedestal_stage1_i,
  input  logic [gpc_pkg::Q8_W-1:0]           pedestal_stage2_i,
  input  logic [gpc_pkg::Q8_W-1:0]           noise_rms_i,
  output gpc_pkg::trk_t                      trk_o
);

  // stage 1: decode, tracking window, weighted sum, output index
  gpc_pkg::side_t                    side1_d, side1_q;
  logic signed [gpc_pkg::GAIN_W-1:0] gain1_d, gain1_q;
  logic [gpc_pkg::Q8_W-1:0]          alt1_d, alt1_q;
  logic [gpc_pkg::NUM_W-1:0]         num1_d, num1_q;
  logic                              trk1_d, trk1_q;

  logic [gpc_pkg::Q8_W-1:0]          adc_q8;
  logic signed [gpc_pkg::DIFF_W-1:0] dev;
  logic [gpc_pkg::DIFF_W-1:0]        dev_abs;
  logic [gpc_pkg::IDX_W-1:0]         col_grp;
  logic [gpc_pkg::OIDX_W-1:0]        oidx;

  always_comb begin
    side1_d.code = gpc_pkg::gain_code_e'(raw_word_i[15:14]);
    side1_d.adc  = raw_word_i[gpc_pkg::ADC_W-1:0];
    side1_d.p0   = pedestal_stage0_i;
    adc_q8       = {raw_word_i[gpc_pkg::ADC_W-1:0], 8'd0};

    dev     = $signed({1'b0, adc_q8}) - $signed({1'b0, pedestal_stage0_i});
    dev_abs = dev[gpc_pkg::DIFF_W-1] ? gpc_pkg::DIFF_W'(-dev) : gpc_pkg::DIFF_W'(dev);
    trk1_d  = (side1_d.code == gpc_pkg::GAIN_STAGE0) && (dev_abs < {noise_rms_i, 1'b0});

    num1_d = gpc_pkg::NUM_W'(pedestal_stage0_i) * gpc_pkg::NUM_W'(gpc_pkg::TRACK_WEIGHT)
           + gpc_pkg::NUM_W'(adc_q8) + gpc_pkg::TRACK_ROUND;

    case (side1_d.code)
      gpc_pkg::GAIN_STAGE0: gain1_d = gain_stage0_i;
      gpc_pkg::GAIN_STAGE1: gain1_d = gain_stage1_i;
      default:              gain1_d = gain_stage2_i;
    endcase
    alt1_d = (side1_d.code == gpc_pkg::GAIN_STAGE1) ? pedestal_stage1_i : pedestal_stage2_i;

    col_grp = gpc_pkg::IDX_W'(pixel_index_i[gpc_pkg::ROW_BITS-1:gpc_pkg::GAP_BITS]);
    oidx    = gpc_pkg::OIDX_W'(pixel_index_i) + {col_grp, 1'b0};
    if (pixel_index_i >= gpc_pkg::LINE_MIN) begin
      oidx = oidx + gpc_pkg::WIDE_GAP;
    end
    side1_d.oidx = oidx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side1_q <= side1_d;
      gain1_q <= gain1_d;
      alt1_q  <= alt1_d;
      num1_q  <= num1_d;
      trk1_q  <= trk1_d;
    end
  end

  // stage 2: divide by 100 through reciprocal multiply
  gpc_pkg::side_t                    side2_q;
  logic signed [gpc_pkg::GAIN_W-1:0] gain2_q;
  logic [gpc_pkg::Q8_W-1:0]          alt2_q;
  logic [gpc_pkg::QPROD_W-1:0]       qprod;
  logic [gpc_pkg::Q8_W-1:0]          p0_2_d, p0_2_q;

  always_comb begin
    qprod  = gpc_pkg::QPROD_W'(num1_q) * gpc_pkg::QPROD_W'(gpc_pkg::DIV100_MUL);
    p0_2_d = trk1_q ? qprod[gpc_pkg::DIV100_SHIFT +: gpc_pkg::Q8_W] : side1_q.p0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side2_q <= side1_q;
      gain2_q <= gain1_q;
      alt2_q  <= alt1_q;
      p0_2_q  <= p0_2_d;
    end
  end

  // stage 3: pedestal subtraction
  gpc_pkg::trk_t            trk3_d, trk3_q;
  logic [gpc_pkg::Q8_W-1:0] ped;

  always_comb begin
    ped              = (side2_q.code == gpc_pkg::GAIN_STAGE0) ? p0_2_q : alt2_q;
    trk3_d.side      = side2_q;
    trk3_d.side.p0   = p0_2_q;
    trk3_d.gain      = gain2_q;
    trk3_d.diff      = $signed({1'b0, side2_q.adc, 8'd0}) - $signed({1'b0, ped});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      trk3_q <= trk3_d;
    end
  end

  assign trk_o = trk3_q;

endmodule

// ===== sv/gpc_scale.sv =====
module gpc_scale (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  gpc_pkg::trk_t                      trk_i,
  output logic signed [gpc_pkg::RES_W-1:0]   corrected_value_o,
  output logic [gpc_pkg::OIDX_W-1:0]         out_index_o,
  output logic [1:0]                         status_o,
  output logic [gpc_pkg::Q8_W-1:0]           new_pedestal_stage0_o
);

  // stage 4: gain multiply
  gpc_pkg::side_t                    side4_q;
  logic signed [gpc_pkg::PROD_W-1:0] prod4_d, prod4_q;

  assign prod4_d = $signed(trk_i.diff) * $signed(trk_i.gain);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side4_q <= trk_i.side;
      prod4_q <= prod4_d;
    end
  end

  // stage 5: magnitude
  gpc_pkg::side_t             side5_q;
  logic                       neg5_q;
  logic [gpc_pkg::PROD_W-1:0] mag5_d, mag5_q;

  assign mag5_d = prod4_q[gpc_pkg::PROD_W-1] ? (~prod4_q + gpc_pkg::PROD_W'(1)) : prod4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side5_q <= side4_q;
      neg5_q  <= prod4_q[gpc_pkg::PROD_W-1];
      mag5_q  <= mag5_d;
    end
  end

  // stage 6: round half away from zero, saturate, special codes
  logic [gpc_pkg::PROD_W:0]   rsum;
  logic [gpc_pkg::MAGR_W-1:0] rmag;
  logic [gpc_pkg::RES_W-1:0]  val6_d, val6_q;
  gpc_pkg::status_e           stat6_d, stat6_q;
  logic [gpc_pkg::OIDX_W-1:0] oidx6_q;
  logic [gpc_pkg::Q8_W-1:0]   p0_6_q;

  always_comb begin
    rsum = {1'b0, mag5_q} + gpc_pkg::ROUND_HALF;
    rmag = rsum[gpc_pkg::PROD_W:gpc_pkg::ROUND_SHIFT];
    if (neg5_q) begin
      val6_d = (rmag > gpc_pkg::NEG_LIMIT) ? gpc_pkg::RES_MIN
                                           : gpc_pkg::RES_W'(~rmag + gpc_pkg::MAGR_W'(1));
    end else begin
      val6_d = (rmag > gpc_pkg::POS_LIMIT) ? gpc_pkg::RES_MAX : gpc_pkg::RES_W'(rmag);
    end
    stat6_d = gpc_pkg::STATUS_NORMAL;
    case (side5_q.code)
      gpc_pkg::GAIN_STAGE2: begin
        if (side5_q.adc == gpc_pkg::ADC_ZERO) begin
          val6_d  = gpc_pkg::RES_MIN;
          stat6_d = gpc_pkg::STATUS_ZERO;
        end
        if (side5_q.adc == gpc_pkg::ADC_FULL) begin
          val6_d  = gpc_pkg::RES_MAX;
          stat6_d = gpc_pkg::STATUS_SAT;
        end
      end
      gpc_pkg::GAIN_INVALID: begin
        val6_d  = '0;
        stat6_d = gpc_pkg::STATUS_INVALID;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      val6_q  <= val6_d;
      stat6_q <= stat6_d;
      oidx6_q <= side5_q.oidx;
      p0_6_q  <= side5_q.p0;
    end
  end

  assign corrected_value_o     = $signed(val6_q);
  assign out_index_o           = oidx6_q;
  assign status_o              = stat6_q;
  assign new_pedestal_stage0_o = p0_6_q;

endmodule

// ===== sv/gpc_checker.sv =====
module gpc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [gpc_pkg::RES_W-1:0]  corrected_value_o,
  input logic [gpc_pkg::OIDX_W-1:0]        out_index_o,
  input logic [1:0]                        status_o
);

  // held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(corrected_value_o)
      && $stable(out_index_o) && $stable(status_o))
    else $error("output beat changed while stalled");

  // input only backs up when the pipe is full and the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipe");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gpc_pkg::STATUS_INVALID |-> corrected_value_o == '0)
    else $error("invalid gain code with nonzero value");

  a_special_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gpc_pkg::STATUS_ZERO
      |-> corrected_value_o == $signed(gpc_pkg::RES_MIN))
    else $error("zero reading not at minimum");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gpc_pkg::STATUS_SAT
      |-> corrected_value_o == $signed(gpc_pkg::RES_MAX))
    else $error("saturated pixel not at maximum");

endmodule

bind detector_pixel_gain_pedestal_correct gpc_checker u_gpc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .corrected_value_o (corrected_value_o),
  .out_index_o       (out_index_o),
  .status_o          (status_o)
);

// ===== bench/pixel_correct_checker.sv =====
`timescale 1ns / 1ps
module pixel_correct_checker
  import gpc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [15:0]               raw_word_i,
  input  logic [IDX_W-1:0]          pixel_index_i,
  input  logic signed [GAIN_W-1:0]  gain_stage0_i,
  input  logic signed [GAIN_W-1:0]  gain_stage1_i,
  input  logic signed [GAIN_W-1:0]  gain_stage2_i,
  input  logic [Q8_W-1:0]           pedestal_stage0_i,
  input  logic [Q8_W-1:0]           pedestal_stage1_i,
  input  logic [Q8_W-1:0]           pedestal_stage2_i,
  input  logic [Q8_W-1:0]           noise_rms_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [RES_W-1:0]   corrected_value_i,
  input  logic [OIDX_W-1:0]         out_index_i,
  input  logic [1:0]                status_i,
  input  logic [Q8_W-1:0]           new_pedestal_stage0_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [OIDX_W-1:0]       index;
    status_e                 status;
    logic [Q8_W-1:0]         ped0;
  } pixel_result_t;

  pixel_result_t expected_q[$];

  // (reading - pedestal) * gain, Q.24 -> int16, half away from zero, clamped
  function automatic logic signed [RES_W-1:0] scale_round(input longint diff,
                                                          input logic signed [GAIN_W-1:0] gain);
    longint prod;
    longint mag;
    prod = diff * longint'(gain);
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + 64'sh800000) >>> 24;
    if (prod < 0) begin
      return (mag > 32768) ? RES_MIN : RES_W'(-mag);
    end
    return (mag > 32767) ? RES_MAX : RES_W'(mag);
  endfunction

  function automatic pixel_result_t predict_pixel(
    input logic [15:0]               raw,
    input logic [IDX_W-1:0]          idx,
    input logic signed [GAIN_W-1:0]  g0,
    input logic signed [GAIN_W-1:0]  g1,
    input logic signed [GAIN_W-1:0]  g2,
    input logic [Q8_W-1:0]           ped0,
    input logic [Q8_W-1:0]           ped1,
    input logic [Q8_W-1:0]           ped2,
    input logic [Q8_W-1:0]           rms
  );
    pixel_result_t    r;
    gain_code_e       code;
    logic [ADC_W-1:0] adc;
    longint           adc_q8;
    longint           p0;
    longint           adc_dev;
    int unsigned      col;
    int unsigned      oidx;
    code   = gain_code_e'(raw[15:14]);
    adc    = raw[ADC_W-1:0];
    adc_q8 = longint'(adc) * 256;
    p0     = longint'(ped0);
    r.value  = '0;
    r.status = STATUS_NORMAL;
    case (code)
      GAIN_STAGE0: begin
        adc_dev = adc_q8 - p0;
        if (adc_dev < 0) adc_dev = -adc_dev;
        if (adc_dev < 2 * longint'(rms)) p0 = (99 * p0 + adc_q8 + 50) / 100;
        r.value = scale_round(adc_q8 - p0, g0);
      end
      GAIN_STAGE1: r.value = scale_round(adc_q8 - longint'(ped1), g1);
      GAIN_STAGE2: begin
        r.value = scale_round(adc_q8 - longint'(ped2), g2);
        if (adc == ADC_ZERO) begin
          r.value  = RES_MIN;
          r.status = STATUS_ZERO;
        end
        if (adc == ADC_FULL) begin
          r.value  = RES_MAX;
          r.status = STATUS_SAT;
        end
      end
      default: begin
        r.value  = '0;
        r.status = STATUS_INVALID;
      end
    endcase
    col  = int'(idx) % ROW_PIXELS;
    oidx = int'(idx) + 2 * (col / 256);
    if (int'(idx) / ROW_PIXELS > 255) oidx += 2 * OUT_ROW_PIXELS;
    r.index = OIDX_W'(oidx);
    r.ped0  = Q8_W'(p0);
    return r;
  endfunction

  always @(posedge clk_i) begin
    pixel_result_t seen;
    pixel_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        seen.value  = corrected_value_i;
        seen.index  = out_index_i;
        seen.status = status_e'(status_i);
        seen.ped0   = new_pedestal_stage0_i;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: output beat with none expected: value %0d index %0d status %0d ped0 %0d",
                     $realtime, seen.value, seen.index, seen.status, seen.ped0);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  value  exp %0d act %0d", want.value, seen.value);
              $display("  index  exp %0d act %0d", want.index, seen.index);
              $display("  status exp %0d act %0d", want.status, seen.status);
              $display("  ped0   exp %0d act %0d", want.ped0, seen.ped0);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_pixel(raw_word_i, pixel_index_i, gain_stage0_i,
                                           gain_stage1_i, gain_stage2_i, pedestal_stage0_i,
                                           pedestal_stage1_i, pedestal_stage2_i, noise_rms_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/tb_detector_pixel_gain_pedestal_correct.sv =====
`timescale 1ns / 1ps
module tb_detector_pixel_gain_pedestal_correct;
  import gpc_pkg::*;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [15:0]               raw_word_i;
  logic [IDX_W-1:0]          pixel_index_i;
  logic signed [GAIN_W-1:0]  gain_stage0_i;
  logic signed [GAIN_W-1:0]  gain_stage1_i;
  logic signed [GAIN_W-1:0]  gain_stage2_i;
  logic [Q8_W-1:0]           pedestal_stage0_i;
  logic [Q8_W-1:0]           pedestal_stage1_i;
  logic [Q8_W-1:0]           pedestal_stage2_i;
  logic [Q8_W-1:0]           noise_rms_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [RES_W-1:0]   corrected_value_o;
  logic [OIDX_W-1:0]         out_index_o;
  logic [1:0]                status_o;
  logic [Q8_W-1:0]           new_pedestal_stage0_o;

  int fail_count;
  int pending;
  int send_idle_pct;
  int stall_pct;
  bit hold_off;

  typedef struct {
    logic [15:0]              raw;
    logic [IDX_W-1:0]         idx;
    logic signed [GAIN_W-1:0] g0;
    logic signed [GAIN_W-1:0] g1;
    logic signed [GAIN_W-1:0] g2;
    logic [Q8_W-1:0]          p0;
    logic [Q8_W-1:0]          p1;
    logic [Q8_W-1:0]          p2;
    logic [Q8_W-1:0]          rms;
  } pixel_beat_t;

  detector_pixel_gain_pedestal_correct dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .raw_word_i            (raw_word_i),
    .pixel_index_i         (pixel_index_i),
    .gain_stage0_i         (gain_stage0_i),
    .gain_stage1_i         (gain_stage1_i),
    .gain_stage2_i         (gain_stage2_i),
    .pedestal_stage0_i     (pedestal_stage0_i),
    .pedestal_stage1_i     (pedestal_stage1_i),
    .pedestal_stage2_i     (pedestal_stage2_i),
    .noise_rms_i           (noise_rms_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .corrected_value_o     (corrected_value_o),
    .out_index_o           (out_index_o),
    .status_o              (status_o),
    .new_pedestal_stage0_o (new_pedestal_stage0_o)
  );

  pixel_correct_checker checker_i (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .raw_word_i            (raw_word_i),
    .pixel_index_i         (pixel_index_i),
    .gain_stage0_i         (gain_stage0_i),
    .gain_stage1_i         (gain_stage1_i),
    .gain_stage2_i         (gain_stage2_i),
    .pedestal_stage0_i     (pedestal_stage0_i),
    .pedestal_stage1_i     (pedestal_stage1_i),
    .pedestal_stage2_i     (pedestal_stage2_i),
    .noise_rms_i           (noise_rms_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .corrected_value_i     (corrected_value_o),
    .out_index_i           (out_index_o),
    .status_i              (status_o),
    .new_pedestal_stage0_i (new_pedestal_stage0_o),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("[detector_pixel_gain_pedestal_correct] ERROR");
    $finish;
  end

  // receiver side
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  function automatic pixel_beat_t rand_pixel();
    pixel_beat_t px;
    int          base;
    px.raw = 16'($urandom);
    px.idx = IDX_W'($urandom);
    px.g0  = GAIN_W'($urandom);
    px.g1  = GAIN_W'($urandom);
    px.g2  = GAIN_W'($urandom);
    px.p0  = Q8_W'($urandom);
    px.p1  = Q8_W'($urandom);
    px.p2  = Q8_W'($urandom);
    px.rms = Q8_W'($urandom);
    if ($urandom_range(9) == 0) px.raw[15:14] = GAIN_INVALID;
    else if (px.raw[15:14] == GAIN_INVALID) px.raw[15:14] = GAIN_STAGE0;
    // most pixels: pedestal close to the reading, gain near unity
    if ($urandom_range(3) != 0) begin
      base   = int'(px.raw[ADC_W-1:0]) * 256;
      px.p0  = Q8_W'(base + int'($urandom_range(8191)) - 4096);
      px.p1  = Q8_W'(base + int'($urandom_range(8191)) - 4096);
      px.p2  = Q8_W'(base + int'($urandom_range(8191)) - 4096);
      px.rms = Q8_W'($urandom_range(4095));
      px.g0  = GAIN_W'(int'($urandom_range(196607)) - 65536);
      px.g1  = GAIN_W'(int'($urandom_range(196607)) - 65536);
      px.g2  = GAIN_W'(int'($urandom_range(196607)) - 65536);
    end
    return px;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_pixel(input pixel_beat_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    raw_word_i        = px.raw;
    pixel_index_i     = px.idx;
    gain_stage0_i     = px.g0;
    gain_stage1_i     = px.g1;
    gain_stage2_i     = px.g2;
    pedestal_stage0_i = px.p0;
    pedestal_stage1_i = px.p1;
    pedestal_stage2_i = px.p2;
    noise_rms_i       = px.rms;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    pixel_beat_t px;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    raw_word_i        = '0;
    pixel_index_i     = '0;
    gain_stage0_i     = '0;
    gain_stage1_i     = '0;
    gain_stage2_i     = '0;
    pedestal_stage0_i = '0;
    pedestal_stage1_i = '0;
    pedestal_stage2_i = '0;
    noise_rms_i       = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // stage 0 tracking inside the window
    px = rand_pixel();
    px.raw = {GAIN_STAGE0, 14'd100}; px.p0 = 22'd25603; px.rms = 22'd256;
    px.g0 = 24'sh010000; px.idx = '0;
    send_pixel(px);
    // distance equal to twice the rms: no tracking
    px.p0 = 22'd25088;
    send_pixel(px);
    // zero rms never tracks
    px.p0 = 22'd25600; px.rms = '0;
    send_pixel(px);
    // stage 0 at full scale and at zero reading
    px = rand_pixel();
    px.raw = {GAIN_STAGE0, ADC_FULL}; px.p0 = '1; px.rms = '1; px.g0 = 24'sh7fffff;
    send_pixel(px);
    px.raw = {GAIN_STAGE0, ADC_ZERO}; px.p0 = '0; px.rms = '1; px.g0 = 24'sh800000;
    send_pixel(px);
    // positive and negative saturation
    px = rand_pixel();
    px.raw = {GAIN_STAGE1, ADC_FULL}; px.p1 = '0; px.g1 = 24'sh7fffff;
    send_pixel(px);
    px.raw = {GAIN_STAGE1, ADC_ZERO}; px.p1 = '1;
    send_pixel(px);
    // exact zero product
    px.raw = {GAIN_STAGE1, 14'd1000}; px.p1 = 22'd256000;
    send_pixel(px);
    // rounding halves away from zero
    px.raw = {GAIN_STAGE1, 14'd1}; px.p1 = 22'd257; px.g1 = 24'sh800000;
    send_pixel(px);
    px.p1 = 22'd255;
    send_pixel(px);
    px.g1 = 24'sh7fffff;
    send_pixel(px);
    // stage 2 zero reading, saturated pixel, normal
    px = rand_pixel();
    px.raw = {GAIN_STAGE2, ADC_ZERO};
    send_pixel(px);
    px.raw = {GAIN_STAGE2, ADC_FULL};
    send_pixel(px);
    px.raw = {GAIN_STAGE2, 14'd5000}; px.p2 = 22'd1279000; px.g2 = 24'sh018000;
    send_pixel(px);
    // invalid gain code
    px = rand_pixel();
    px.raw = {GAIN_INVALID, 14'h2aaa}; px.idx = '1;
    send_pixel(px);
    px.raw = {GAIN_INVALID, 14'h1555}; px.idx = 19'd262144;
    send_pixel(px);
    // index boundaries: chip gaps, upper half, highest index
    px = rand_pixel(); px.idx = 19'd255;    send_pixel(px);
    px = rand_pixel(); px.idx = 19'd256;    send_pixel(px);
    px = rand_pixel(); px.idx = 19'd1023;   send_pixel(px);
    px = rand_pixel(); px.idx = 19'd262143; send_pixel(px);
    px = rand_pixel(); px.idx = 19'd524287; send_pixel(px);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      if (phase == 0) begin
        // long output hold so the pipeline fills and backs up
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (120) send_pixel(rand_pixel());
    end
    in_valid_i    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[detector_pixel_gain_pedestal_correct] OK");
    end else begin
      $display("[detector_pixel_gain_pedestal_correct] ERROR");
    end
    $finish;
  end

endmodule

// ===== detector_pixel_gain_pedestal_correct.f =====
sv/gpc_pkg.sv
sv/gpc_track.sv
sv/gpc_scale.sv
sv/detector_pixel_gain_pedestal_correct.sv
sv/gpc_checker.sv
bench/pixel_correct_checker.sv
bench/tb_detector_pixel_gain_pedestal_correct.sv
